FILE: hdl/bdc_pkg.sv
// shared types and constants for the binary to decimal text converter
`timescale 1ns / 1ps

package bdc_pkg;

  // longest run of characters per input beat
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned LIMIT = (MAX_DIGITS > 20) ? 20 : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PAD_W = 8;
  localparam int unsigned CHAR_W = 6;
  localparam int unsigned DIGIT_W = 4;

  // decimal digits needed to hold any 32-bit value
  localparam int unsigned DIGIT_CELLS = 10;

  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
  localparam int unsigned POS_W = $clog2(LIMIT + DIGIT_CELLS);
  localparam int unsigned DIG_IDX_W = $clog2(DIGIT_CELLS);
  localparam int unsigned SUM_W = ((POS_W > PAD_W) ? POS_W : PAD_W) + 1;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);
  localparam logic [DIGIT_W-1:0] RADIX = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] ADJUST_MIN = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADJUST_ADD = DIGIT_W'(3);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PAD_W-1:0]   extra_zeros;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  // control from the sequencer to every digit cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: hdl/bdc_digit_cell.sv
// one bcd digit cell of the shift-and-add-3 chain
`timescale 1ns / 1ps

module bdc_digit_cell (
  input  logic                          clk_i,
  input  bdc_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          carry_i,
  output logic                          carry_o,
  output logic [bdc_pkg::DIGIT_W-1:0]   digit_o
);

  logic [bdc_pkg::DIGIT_W-1:0] digit_q;
  logic [bdc_pkg::DIGIT_W-1:0] digit_d;
  logic [bdc_pkg::DIGIT_W-1:0] adj;

  // add 3 before the shift so the digit never passes 9
  always_comb begin
    adj = (digit_q >= bdc_pkg::ADJUST_MIN) ? (digit_q + bdc_pkg::ADJUST_ADD) : digit_q;
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[bdc_pkg::DIGIT_W-2:0], carry_i};
    end
  end

  assign carry_o = adj[bdc_pkg::DIGIT_W-1];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

FILE: hdl/binary_to_decimal_ascii_top.sv
// top level of the binary to decimal text converter
`timescale 1ns / 1ps

// Takes one beat holding a 32-bit unsigned value and a count of extra
// zeros, and sends the decimal text of that value as a run of ASCII digit
// beats, most significant first, with the extra zeros in front and the
// final beat marked by last. A zero value gives a single '0', and the run
// is never longer than MAX_DIGITS characters (padding stops there, and
// only the lowest digits are kept if the value has more). Each input beat
// is shifted through the chain of ten bcd digit cells (one binary bit
// shifted in per cycle), then the significant digits are counted to size
// the run, then the characters go out one per cycle through the output
// register while the output does not stall. The input is stalled while a
// beat is in work; the next one is taken as soon as the final character
// is in the output register.

module binary_to_decimal_ascii_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bdc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bdc_pkg::out_t out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CONV  = 4'b0010,
    S_COUNT = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [bdc_pkg::VALUE_W-1:0]   value_q, value_d;
  logic [bdc_pkg::PAD_W-1:0]     pad_q, pad_d;
  logic [bdc_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [bdc_pkg::POS_W-1:0]     pos_q, pos_d;
  logic                          out_valid_q, out_valid_d;
  bdc_pkg::out_t                 out_data_q, out_data_d;

  logic in_accept;
  logic slot_free;

  bdc_pkg::cell_ctrl_t cell_ctrl;
  logic [bdc_pkg::DIGIT_CELLS:0] carry;
  logic [bdc_pkg::DIGIT_W-1:0]   digit [bdc_pkg::DIGIT_CELLS];

  // run sizing
  logic [bdc_pkg::POS_W-1:0] ndig;
  logic [bdc_pkg::POS_W-1:0] ndig_c;
  logic [bdc_pkg::SUM_W-1:0] run_sum;
  logic [bdc_pkg::SUM_W-1:0] run_len;
  logic [bdc_pkg::DIGIT_W-1:0] cur_digit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the chain: binary msb enters cell 0, carries ripple upward one cell per cycle
  assign cell_ctrl.clear = in_accept;
  assign cell_ctrl.shift = (state_q == S_CONV);
  assign carry[0] = value_q[bdc_pkg::VALUE_W-1];

  for (genvar g = 0; g < bdc_pkg::DIGIT_CELLS; g++) begin : g_cell
    bdc_digit_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry[g]),
      .carry_o (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  // highest nonzero digit sets the significant length, at least one digit
  always_comb begin
    ndig = bdc_pkg::POS_W'(1);
    for (int i = 0; i < bdc_pkg::DIGIT_CELLS; i++) begin
      if (digit[i] != '0) begin
        ndig = bdc_pkg::POS_W'(i + 1);
      end
    end
    ndig_c  = (ndig > bdc_pkg::POS_W'(bdc_pkg::LIMIT)) ? bdc_pkg::POS_W'(bdc_pkg::LIMIT) : ndig;
    run_sum = bdc_pkg::SUM_W'(ndig_c) + bdc_pkg::SUM_W'(pad_q);
    run_len = (run_sum > bdc_pkg::SUM_W'(bdc_pkg::LIMIT)) ?
              bdc_pkg::SUM_W'(bdc_pkg::LIMIT) : run_sum;
  end

  // padding positions above the digit cells always read as zero
  assign cur_digit = (pos_q < bdc_pkg::POS_W'(bdc_pkg::DIGIT_CELLS)) ?
                     digit[pos_q[bdc_pkg::DIG_IDX_W-1:0]] : '0;

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    pad_d       = pad_q;
    bit_cnt_d   = bit_cnt_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // output register drains independently of the sequencer
    if (slot_free) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          value_d   = in_data_i.value;
          pad_d     = in_data_i.extra_zeros;
          bit_cnt_d = '0;
          state_d   = S_CONV;
        end
      end
      S_CONV: begin
        value_d   = {value_q[bdc_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == bdc_pkg::BIT_CNT_W'(bdc_pkg::VALUE_W - 1)) begin
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        pos_d   = bdc_pkg::POS_W'(run_len - 1'b1);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_data_d.character = bdc_pkg::ASCII_ZERO + bdc_pkg::CHAR_W'(cur_digit);
          out_data_d.last      = (pos_q == '0);
          if (pos_q == '0) begin
            state_d = S_IDLE;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    pad_q      <= pad_d;
    pos_q      <= pos_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTHESIS
  // the lowest and the top cell hold a legal bcd digit once the conversion has finished
  a_bcd_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COUNT) |-> (digit[bdc_pkg::DIGIT_CELLS-1] < bdc_pkg::RADIX &&
                              digit[0] < bdc_pkg::RADIX))
    else $error("bcd digit out of range after conversion");

  // sizing only follows a finished conversion
  a_count_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COUNT) |-> ($past(state_q) == S_CONV &&
                              $past(bit_cnt_q) == bdc_pkg::BIT_CNT_W'(bdc_pkg::VALUE_W - 1)))
    else $error("digit count entered without a full conversion");

  // the run position never reaches past the length limit
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (pos_q < bdc_pkg::POS_W'(bdc_pkg::LIMIT)))
    else $error("run position beyond limit");

  // only decimal digit characters leave the block
  a_char_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.character >= bdc_pkg::ASCII_ZERO &&
                     out_data_o.character <= bdc_pkg::ASCII_NINE))
    else $error("non-digit character on output");

  // ten digits always hold a 32-bit value, so the top cell never carries out
  a_no_carry_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> !carry[bdc_pkg::DIGIT_CELLS])
    else $error("carry out of the top digit cell");
`endif

endmodule
